// ===== hdl/twb_pkg.sv =====
// Shared constants and types for the trajectory work balancer.
package twb_pkg;

  localparam int MAX_THREADS  = 64;
  localparam int MAX_CIRCUITS = 4096;
  localparam int HEIGHT_CAP   = 2 * MAX_CIRCUITS;

  localparam int COUNT_W  = 16;
  localparam int TCNT_W   = 7;
  localparam int IDX_W    = 6;
  localparam int HEIGHT_W = 14;
  localparam int TOP_W    = 15;

  // Remainder unit resolves one dividend bit per cycle.
  localparam int DIV_STEPS = COUNT_W;
  localparam int STEP_W    = 5;

  typedef struct packed {
    logic [TCNT_W-1:0]       num_lo;
    logic [TCNT_W-1:0]       num_hi;
    logic [TCNT_W-1:0]       remain;
    logic signed [TOP_W-1:0] run_max;
  } twb_tok_data_t;

  typedef struct packed {
    logic          valid;
    twb_tok_data_t data;
  } twb_tok_t;

  typedef struct packed {
    logic                    valid;
    logic                    off;
    logic                    last;
    logic signed [TOP_W-1:0] run_max;
  } twb_res_t;

endpackage

// ===== hdl/twb_cell.sv =====
// One worker cell: holds the worker's height and makes its share decision when the token arrives.
module twb_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             clear,
  input  logic                             advance,
  input  logic signed [twb_pkg::TOP_W-1:0] cur_max,
  input  twb_pkg::twb_tok_t                tok_in,
  output twb_pkg::twb_tok_t                tok_out,
  output twb_pkg::twb_res_t                res_out
);
  import twb_pkg::*;

  logic [HEIGHT_W-1:0]     height_r, height_nxt;
  logic                    tok_valid_r, tok_valid_nxt;
  twb_tok_data_t           tok_r;

  logic signed [HEIGHT_W+1:0] h_ext, cm_ext;
  logic                       take_lo, use_hi, fire;
  logic [HEIGHT_W:0]          sum;
  logic [HEIGHT_W-1:0]        h_new;
  logic signed [TOP_W-1:0]    h_new_s, max_new;
  logic [TCNT_W-1:0]          lo_new, hi_new;

  always_comb begin
    h_ext   = signed'({2'b00, height_r});
    cm_ext  = signed'({cur_max[TOP_W-1], cur_max});
    // A worker sitting at the old top takes a reduced share while any are left.
    take_lo = (h_ext == cm_ext) && (tok_r.num_lo != '0);
    use_hi  = !take_lo && (tok_r.num_hi != '0);
    fire    = tok_valid_r && advance;
    sum     = {1'b0, height_r} + (use_hi ? (HEIGHT_W+1)'(2) : (HEIGHT_W+1)'(1));
    h_new   = (sum > (HEIGHT_W+1)'(HEIGHT_CAP)) ? HEIGHT_W'(HEIGHT_CAP)
                                                  : sum[HEIGHT_W-1:0];
    h_new_s = signed'({1'b0, h_new});
    max_new = (h_new_s > tok_r.run_max) ? h_new_s : tok_r.run_max;
    lo_new  = (!use_hi && (tok_r.num_lo != '0)) ? tok_r.num_lo - 1'b1 : tok_r.num_lo;
    hi_new  = use_hi ? tok_r.num_hi - 1'b1 : tok_r.num_hi;

    height_nxt = clear ? '0 : (fire ? h_new : height_r);
    if (tok_in.valid) begin
      tok_valid_nxt = 1'b1;
    end else if (fire) begin
      tok_valid_nxt = 1'b0;
    end else begin
      tok_valid_nxt = tok_valid_r;
    end

    tok_out.valid          = fire && (tok_r.remain != TCNT_W'(1));
    tok_out.data.num_lo    = lo_new;
    tok_out.data.num_hi    = hi_new;
    tok_out.data.remain    = tok_r.remain - 1'b1;
    tok_out.data.run_max   = max_new;

    // Fields are gated so the top level can OR all cells together.
    res_out.valid   = tok_valid_r;
    res_out.off     = tok_valid_r && !use_hi;
    res_out.last    = tok_valid_r && (tok_r.remain == TCNT_W'(1));
    res_out.run_max = tok_valid_r ? max_new : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= '0;
      tok_valid_r <= 1'b0;
    end else begin
      height_r    <= height_nxt;
      tok_valid_r <= tok_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (tok_in.valid) begin
      tok_r <= tok_in.data;
    end
  end

endmodule

// ===== hdl/twb_rem_div.sv =====
// Restoring remainder unit: dividend modulo divisor, one dividend bit per cycle.
module twb_rem_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [twb_pkg::COUNT_W-1:0]   dividend,
  input  logic [twb_pkg::TCNT_W-1:0]    divisor,
  output logic                          done,
  output logic [twb_pkg::TCNT_W-1:0]    remainder
);
  import twb_pkg::*;

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [COUNT_W-1:0]  num_r, num_nxt;
  logic [TCNT_W-1:0]   rem_r, rem_nxt;
  logic [TCNT_W-1:0]   div_r, div_nxt;
  logic [TCNT_W-1:0]   shifted;

  always_comb begin
    // The partial remainder stays below the divisor, so its top bit is free.
    shifted  = {rem_r[TCNT_W-2:0], num_r[COUNT_W-1]};
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = STEP_W'(DIV_STEPS);
      num_nxt = dividend;
      rem_nxt = '0;
      div_nxt = divisor;
    end else if (run_r) begin
      rem_nxt = (shifted >= div_r) ? shifted - div_r : shifted;
      num_nxt = {num_r[COUNT_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// ===== hdl/trajectory_work_balancer_unit.sv =====
// Top level of the trajectory work balancer: control, remainder unit and the worker cell chain.
// A count that does not end a circuit is taken without holding the input.
// A circuit-ending count holds the input, for T workers, through the transfer, the bit-serial
// remainder of the limit by T, loading the token and then each worker in turn.
// Results stream one per cycle while the output is not stalled.
// Synchronous active-low reset clears all heights, sets the top height to minus one,
// the limit to zero and the worker count to one.
module trajectory_work_balancer_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [twb_pkg::COUNT_W-1:0]   in_sample_count,
  input  logic                          in_last_of_circuit,
  input  logic                          in_start_of_batch,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [twb_pkg::IDX_W-1:0]     out_thread_index,
  output logic signed                   out_offset,
  output logic                          out_last_of_run,
  input  logic                          cfg_wr_en,
  input  logic [twb_pkg::TCNT_W-1:0]    cfg_wr_data
);
  import twb_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_WALK} state_t;

  state_t                  state_r, state_nxt;
  logic [TCNT_W-1:0]       thread_count_r, thread_count_nxt;
  logic [COUNT_W-1:0]      limit_r, limit_nxt;
  logic [TCNT_W-1:0]       t_r, t_nxt;
  logic signed [TOP_W-1:0] top_r, top_nxt;
  logic [IDX_W-1:0]        idx_r, idx_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]        out_idx_r, out_idx_nxt;
  logic                    out_off_r, out_off_nxt;
  logic                    out_last_r, out_last_nxt;

  logic                    in_xfer, clear, advance, emit;
  logic [COUNT_W-1:0]      base, limit_new;
  logic [TCNT_W-1:0]       t_eff, rem, lo_cnt;
  logic                    div_start, div_done;
  twb_tok_t                inject;
  twb_tok_t                tok_link [MAX_THREADS];
  twb_res_t                res_cell [MAX_THREADS];
  twb_res_t                res_any;

  assign in_stall  = (state_r != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign clear     = in_xfer && in_start_of_batch;
  assign advance   = !out_valid_r || !out_stall;
  assign div_start = in_xfer && in_last_of_circuit;

  always_comb begin
    base      = in_start_of_batch ? '0 : limit_r;
    limit_new = (in_sample_count > base) ? in_sample_count : base;
    if (thread_count_r == '0) begin
      t_eff = TCNT_W'(1);
    end else if (thread_count_r > TCNT_W'(MAX_THREADS)) begin
      t_eff = TCNT_W'(MAX_THREADS);
    end else begin
      t_eff = thread_count_r;
    end
  end

  twb_rem_div u_rem_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (limit_new),
    .divisor   (t_eff),
    .done      (div_done),
    .remainder (rem)
  );

  // Workers short of a full ceiling share: (T - L mod T) mod T.
  always_comb begin
    lo_cnt               = (rem == '0) ? '0 : t_r - rem;
    inject.valid         = (state_r == S_DIV) && div_done;
    inject.data.num_lo   = lo_cnt;
    inject.data.num_hi   = t_r - lo_cnt;
    inject.data.remain   = t_r;
    inject.data.run_max  = top_r;
  end

  for (genvar k = 0; k < MAX_THREADS; k++) begin : g_cell
    twb_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .clear   (clear),
      .advance (advance),
      .cur_max (top_r),
      .tok_in  ((k == 0) ? inject : tok_link[(k == 0) ? 0 : k - 1]),
      .tok_out (tok_link[k]),
      .res_out (res_cell[k])
    );
  end

  // Only the cell holding the token drives nonzero result fields.
  always_comb begin
    res_any = '0;
    for (int k = 0; k < MAX_THREADS; k++) begin
      res_any = res_any | res_cell[k];
    end
  end

  assign emit = res_any.valid && advance;

  always_comb begin
    state_nxt        = state_r;
    thread_count_nxt = cfg_wr_en ? cfg_wr_data : thread_count_r;
    limit_nxt        = limit_r;
    t_nxt            = t_r;
    top_nxt          = top_r;
    idx_nxt          = idx_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_idx_nxt      = out_idx_r;
    out_off_nxt      = out_off_r;
    out_last_nxt     = out_last_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_idx_nxt   = idx_r;
      out_off_nxt   = res_any.off;
      out_last_nxt  = res_any.last;
      idx_nxt       = idx_r + 1'b1;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_start_of_batch) begin
            top_nxt = '1;
          end
          if (in_last_of_circuit) begin
            limit_nxt = '0;
            t_nxt     = t_eff;
            state_nxt = S_DIV;
          end else begin
            limit_nxt = limit_new;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          idx_nxt   = '0;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (emit && res_any.last) begin
          top_nxt   = res_any.run_max;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      thread_count_r <= TCNT_W'(1);
      limit_r        <= '0;
      t_r            <= TCNT_W'(1);
      top_r          <= '1;
      idx_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      thread_count_r <= thread_count_nxt;
      limit_r        <= limit_nxt;
      t_r            <= t_nxt;
      top_r          <= top_nxt;
      idx_r          <= idx_nxt;
      out_valid_r    <= out_valid_nxt;
    end
    out_idx_r  <= out_idx_nxt;
    out_off_r  <= out_off_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_thread_index = out_idx_r;
  assign out_offset       = out_off_r;
  assign out_last_of_run  = out_last_r;

endmodule

// ===== hdl/twb_checker.sv =====
// Port-level checks for the trajectory work balancer, bound to the top level.
module twb_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic [twb_pkg::COUNT_W-1:0]   in_sample_count,
  input logic                          in_last_of_circuit,
  input logic                          in_start_of_batch,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [twb_pkg::IDX_W-1:0]     out_thread_index,
  input logic signed                   out_offset,
  input logic                          out_last_of_run,
  input logic                          cfg_wr_en,
  input logic [twb_pkg::TCNT_W-1:0]    cfg_wr_data
);
  import twb_pkg::*;

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_thread_index)
      && $stable(out_offset) && $stable(out_last_of_run))
    else $error("result changed while stalled");

  // Results of one circuit follow back to back with consecutive worker numbers.
  a_out_seq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=>
      out_valid && (out_thread_index == $past(out_thread_index) + 1'b1))
    else $error("worker results not consecutive");

  // Only a circuit-ending transfer makes the input busy.
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall == $past(in_last_of_circuit))
    else $error("input busy does not follow circuit end");

  // Input stays blocked until the last worker's result is produced.
  a_walk_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last_of_run |-> in_stall)
    else $error("input taken during a distribution");

endmodule

bind trajectory_work_balancer_unit twb_checker u_twb_checker (.*);
